### hdl/utfv_pkg.sv
// Shared types, codes and constants of the UTF-8 stream validator.
package utfv_pkg;

    // Defaults of the top-level parameters
    localparam int UTFV_MAX_SUPPORTED_DEPTH = 256;
    localparam int UTFV_COUNTER_WIDTH       = 32;

    // Register indexes (paddr[2]) and reset values
    localparam logic UTFV_REG_MAX_FILE_BYTES    = 1'b0;
    localparam logic UTFV_REG_MAX_NESTING_DEPTH = 1'b1;
    localparam logic [31:0] UTFV_MAX_FILE_BYTES_RST    = 32'd1048576;
    localparam logic [15:0] UTFV_MAX_NESTING_DEPTH_RST = 16'd64;

    // Byte values
    localparam logic [7:0] UTFV_BOM_0      = 8'hEF;
    localparam logic [7:0] UTFV_BOM_1      = 8'hBB;
    localparam logic [7:0] UTFV_BOM_2      = 8'hBF;
    localparam logic [7:0] UTFV_ASCII_MAX  = 8'h7F;
    localparam logic [7:0] UTFV_LF         = 8'h0A;
    localparam logic [7:0] UTFV_CR         = 8'h0D;
    localparam logic [7:0] UTFV_LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] UTFV_LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] UTFV_LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] UTFV_LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] UTFV_LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] UTFV_LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] UTFV_LEAD_E0    = 8'hE0;
    localparam logic [7:0] UTFV_LEAD_ED    = 8'hED;
    localparam logic [7:0] UTFV_LEAD_F0    = 8'hF0;
    localparam logic [7:0] UTFV_LEAD_F4    = 8'hF4;
    localparam logic [7:0] UTFV_CONT_MASK  = 8'hC0;
    localparam logic [7:0] UTFV_CONT_TAG   = 8'h80;
    localparam logic [7:0] UTFV_LIM_A0     = 8'hA0;
    localparam logic [7:0] UTFV_LIM_90     = 8'h90;
    localparam logic [7:0] UTFV_LIM_8F     = 8'h8F;

    // Byte order mark tracking codes
    localparam logic [1:0] UTFV_BOM_START = 2'd0;
    localparam logic [1:0] UTFV_BOM_GOT1  = 2'd1;
    localparam logic [1:0] UTFV_BOM_GOT2  = 2'd2;
    localparam logic [1:0] UTFV_BOM_DONE  = 2'd3;

    localparam logic [1:0] UTFV_BOM_SHIFT = 2'd3;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_E0,
        RULE_ED,
        RULE_F0,
        RULE_F4
    } t_rule;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_TOO_LARGE,
        STATUS_BAD_DEPTH,
        STATUS_BAD_UTF8
    } t_status;

    typedef struct packed {
        logic [31:0] max_file_bytes;
        logic [15:0] max_nesting_depth;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        has_bom;
        logic [1:0]  offset_shift;
        logic [31:0] content_bytes;
        logic [31:0] error_line;
        logic [31:0] error_column;
    } t_result;

endpackage

### hdl/utfv_cfg.sv
// APB-style configuration registers of the UTF-8 stream validator.
module utfv_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output utfv_pkg::t_cfg    o_cfg
);

    logic [31:0] r_max_file_bytes;
    logic [15:0] r_max_nesting_depth;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_file_bytes    <= utfv_pkg::UTFV_MAX_FILE_BYTES_RST;
            r_max_nesting_depth <= utfv_pkg::UTFV_MAX_NESTING_DEPTH_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                utfv_pkg::UTFV_REG_MAX_FILE_BYTES:    r_max_file_bytes    <= pwdata;
                utfv_pkg::UTFV_REG_MAX_NESTING_DEPTH: r_max_nesting_depth <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            utfv_pkg::UTFV_REG_MAX_FILE_BYTES:    prdata = r_max_file_bytes;
            utfv_pkg::UTFV_REG_MAX_NESTING_DEPTH: prdata = {16'd0, r_max_nesting_depth};
            default:                              prdata = 32'd0;
        endcase
    end

    assign o_cfg.max_file_bytes    = r_max_file_bytes;
    assign o_cfg.max_nesting_depth = r_max_nesting_depth;

endmodule

### hdl/utfv_step.sv
// Per-byte UTF-8 check, BOM tracking, line/column counting and end-of-file result.
module utfv_step #(
    parameter int MAX_SUPPORTED_DEPTH = utfv_pkg::UTFV_MAX_SUPPORTED_DEPTH,
    parameter int COUNTER_WIDTH       = utfv_pkg::UTFV_COUNTER_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data_byte,
    input  logic                i_has_byte,
    input  logic                i_is_last,
    input  utfv_pkg::t_cfg      i_cfg,
    output utfv_pkg::t_result   o_result
);

    localparam int CW = COUNTER_WIDTH;
    localparam int EW = (CW > 32) ? CW : 32;
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_ZERO = '0;
    localparam logic [16:0]   DEPTH_CEIL = 17'(MAX_SUPPORTED_DEPTH);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [31:0] clip32(input logic [CW-1:0] v);
        logic [EW-1:0] w;
        w = EW'(v);
        return (w > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic rule_ok(input utfv_pkg::t_rule rule, input logic [7:0] b);
        case (rule)
            utfv_pkg::RULE_E0: return b >= utfv_pkg::UTFV_LIM_A0;
            utfv_pkg::RULE_ED: return b <  utfv_pkg::UTFV_LIM_A0;
            utfv_pkg::RULE_F0: return b >= utfv_pkg::UTFV_LIM_90;
            utfv_pkg::RULE_F4: return b <= utfv_pkg::UTFV_LIM_8F;
            default:           return 1'b1;
        endcase
    endfunction

    logic [CW-1:0]   r_byte_count, n_byte_count;
    logic [CW-1:0]   r_line, n_line;
    logic [CW-1:0]   r_col, n_col;
    logic [1:0]      r_cont_left, n_cont_left;
    utfv_pkg::t_rule r_rule, n_rule;
    logic            r_pending_cr, n_pending_cr;
    logic [1:0]      r_bom_trk, n_bom_trk;
    logic            r_bom_seen, n_bom_seen;
    logic            r_err, n_err;
    logic [CW-1:0]   r_err_line, n_err_line;
    logic [CW-1:0]   r_err_col, n_err_col;
    logic            mark_done;
    logic [CW-1:0]   content;
    utfv_pkg::t_status status;

    always_comb begin
        n_byte_count = r_byte_count;
        n_line       = r_line;
        n_col        = r_col;
        n_cont_left  = r_cont_left;
        n_rule       = r_rule;
        n_pending_cr = r_pending_cr;
        n_bom_trk    = r_bom_trk;
        n_bom_seen   = r_bom_seen;
        n_err        = r_err;
        n_err_line   = r_err_line;
        n_err_col    = r_err_col;
        mark_done    = 1'b0;

        if (i_has_byte) begin
            n_byte_count = sat_inc(r_byte_count);

            // Mark detection looks only at the first three raw bytes
            if (r_byte_count == CNT_ZERO) begin
                n_bom_trk = (i_data_byte == utfv_pkg::UTFV_BOM_0) ?
                            utfv_pkg::UTFV_BOM_GOT1 : utfv_pkg::UTFV_BOM_DONE;
            end else if (r_byte_count == CW'(1)) begin
                n_bom_trk = (r_bom_trk == utfv_pkg::UTFV_BOM_GOT1 &&
                             i_data_byte == utfv_pkg::UTFV_BOM_1) ?
                            utfv_pkg::UTFV_BOM_GOT2 : utfv_pkg::UTFV_BOM_DONE;
            end else begin
                if (r_byte_count == CW'(2) && r_bom_trk == utfv_pkg::UTFV_BOM_GOT2 &&
                    i_data_byte == utfv_pkg::UTFV_BOM_2) begin
                    n_bom_seen = 1'b1;
                    mark_done  = 1'b1;
                end
                n_bom_trk = utfv_pkg::UTFV_BOM_DONE;
            end

            if (!r_err) begin
                if (r_cont_left != 2'd0) begin
                    if ((i_data_byte & utfv_pkg::UTFV_CONT_MASK) != utfv_pkg::UTFV_CONT_TAG ||
                        !rule_ok(r_rule, i_data_byte)) begin
                        n_err      = 1'b1;
                        n_err_line = r_line;
                        n_err_col  = r_col;
                    end else begin
                        n_rule      = utfv_pkg::RULE_NONE;
                        n_cont_left = r_cont_left - 2'd1;
                        if (r_cont_left == 2'd1 && !mark_done) begin
                            n_col = sat_inc(r_col);
                        end
                    end
                end else if (!(r_pending_cr && i_data_byte == utfv_pkg::UTFV_LF)) begin
                    n_pending_cr = 1'b0;
                    case (i_data_byte) inside
                        [8'h00 : utfv_pkg::UTFV_ASCII_MAX]: begin
                            if (i_data_byte == utfv_pkg::UTFV_LF ||
                                i_data_byte == utfv_pkg::UTFV_CR) begin
                                n_line       = sat_inc(r_line);
                                n_col        = CNT_ONE;
                                n_pending_cr = (i_data_byte == utfv_pkg::UTFV_CR);
                            end else begin
                                n_col = sat_inc(r_col);
                            end
                        end
                        [utfv_pkg::UTFV_LEAD2_MIN : utfv_pkg::UTFV_LEAD2_MAX]: begin
                            n_cont_left = 2'd1;
                            n_rule      = utfv_pkg::RULE_NONE;
                        end
                        [utfv_pkg::UTFV_LEAD3_MIN : utfv_pkg::UTFV_LEAD3_MAX]: begin
                            n_cont_left = 2'd2;
                            n_rule = (i_data_byte == utfv_pkg::UTFV_LEAD_E0) ? utfv_pkg::RULE_E0 :
                                     (i_data_byte == utfv_pkg::UTFV_LEAD_ED) ? utfv_pkg::RULE_ED :
                                     utfv_pkg::RULE_NONE;
                        end
                        [utfv_pkg::UTFV_LEAD4_MIN : utfv_pkg::UTFV_LEAD4_MAX]: begin
                            n_cont_left = 2'd3;
                            n_rule = (i_data_byte == utfv_pkg::UTFV_LEAD_F0) ? utfv_pkg::RULE_F0 :
                                     (i_data_byte == utfv_pkg::UTFV_LEAD_F4) ? utfv_pkg::RULE_F4 :
                                     utfv_pkg::RULE_NONE;
                        end
                        default: begin
                            n_err      = 1'b1;
                            n_err_line = r_line;
                            n_err_col  = r_col;
                        end
                    endcase
                end else begin
                    // LF right after CR: absorb into the same break
                    n_pending_cr = 1'b0;
                end
            end
        end

        // Truncated sequence at end of file reports at its lead byte
        if (i_is_last && !n_err && n_cont_left != 2'd0) begin
            n_err      = 1'b1;
            n_err_line = n_line;
            n_err_col  = n_col;
        end
    end

    always_comb begin
        if (EW'(n_byte_count) > EW'(i_cfg.max_file_bytes)) begin
            status = utfv_pkg::STATUS_TOO_LARGE;
        end else if ({1'b0, i_cfg.max_nesting_depth} > DEPTH_CEIL) begin
            status = utfv_pkg::STATUS_BAD_DEPTH;
        end else if (n_err) begin
            status = utfv_pkg::STATUS_BAD_UTF8;
        end else begin
            status = utfv_pkg::STATUS_OK;
        end
        content = n_bom_seen ? n_byte_count - CW'(3) : n_byte_count;

        o_result.status        = status;
        o_result.has_bom       = n_bom_seen;
        o_result.offset_shift  = n_bom_seen ? utfv_pkg::UTFV_BOM_SHIFT : 2'd0;
        o_result.content_bytes = clip32(content);
        o_result.error_line    = (status == utfv_pkg::STATUS_BAD_UTF8) ? clip32(n_err_line) : 32'd0;
        o_result.error_column  = (status == utfv_pkg::STATUS_BAD_UTF8) ? clip32(n_err_col) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_is_last)) begin
            r_byte_count <= CNT_ZERO;
            r_line       <= CNT_ONE;
            r_col        <= CNT_ONE;
            r_cont_left  <= 2'd0;
            r_rule       <= utfv_pkg::RULE_NONE;
            r_pending_cr <= 1'b0;
            r_bom_trk    <= utfv_pkg::UTFV_BOM_START;
            r_bom_seen   <= 1'b0;
            r_err        <= 1'b0;
            r_err_line   <= CNT_ZERO;
            r_err_col    <= CNT_ZERO;
        end else if (i_fire) begin
            r_byte_count <= n_byte_count;
            r_line       <= n_line;
            r_col        <= n_col;
            r_cont_left  <= n_cont_left;
            r_rule       <= n_rule;
            r_pending_cr <= n_pending_cr;
            r_bom_trk    <= n_bom_trk;
            r_bom_seen   <= n_bom_seen;
            r_err        <= n_err;
            r_err_line   <= n_err_line;
            r_err_col    <= n_err_col;
        end
    end

endmodule

### hdl/utfv_out.sv
// Result register of the UTF-8 stream validator.
module utfv_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  utfv_pkg::t_result   i_result,
    input  logic                i_stall,
    output logic                o_valid,
    output utfv_pkg::t_result   o_result
);

    logic              r_valid;
    utfv_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hdl/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: input register, step logic, result register.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_data_byte, i_has_byte, i_is_last
//  out      | out       | o_out_valid / i_out_stall | o_status, o_has_bom, o_offset_shift,
//           |           |                           | o_content_bytes, o_error_line/column
//  cfg      | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One byte per cycle unless a last transaction is held back: each accepted transaction is held in
// the input register, and the byte check plus counter update runs as it leaves; the result of a
// last transaction lands in the result register, from which it can leave when not stalled.
// A last transaction waits in the input register only while the result register holds an
// untaken result that is stalled; other transactions never wait.
// Synchronous active-low reset empties both registers, clears all file state and restores
// max_file_bytes = 1048576 and max_nesting_depth = 64. After each result file state clears.
module utf8_stream_validator #(
    parameter int MAX_SUPPORTED_DEPTH = utfv_pkg::UTFV_MAX_SUPPORTED_DEPTH,
    parameter int COUNTER_WIDTH       = utfv_pkg::UTFV_COUNTER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_has_bom,
    output logic [1:0]  o_offset_shift,
    output logic [31:0] o_content_bytes,
    output logic [31:0] o_error_line,
    output logic [31:0] o_error_column,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    utfv_pkg::t_cfg    cfg;
    utfv_pkg::t_result step_result;
    utfv_pkg::t_result out_result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_has;
    logic       r_in_last;
    logic       in_accept;
    logic       consume;

    // Advance the held transaction unless it is a last one and the result slot is blocked
    assign consume    = r_in_valid && (!r_in_last || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold payload until the next accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_has  <= i_has_byte;
            r_in_last <= i_is_last;
        end
    end

    utfv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    utfv_step #(
        .MAX_SUPPORTED_DEPTH (MAX_SUPPORTED_DEPTH),
        .COUNTER_WIDTH       (COUNTER_WIDTH)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (consume),
        .i_data_byte (r_in_byte),
        .i_has_byte  (r_in_has),
        .i_is_last   (r_in_last),
        .i_cfg       (cfg),
        .o_result    (step_result)
    );

    // Load the result only from a last transaction
    utfv_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume && r_in_last),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_status        = out_result.status;
    assign o_has_bom       = out_result.has_bom;
    assign o_offset_shift  = out_result.offset_shift;
    assign o_content_bytes = out_result.content_bytes;
    assign o_error_line    = out_result.error_line;
    assign o_error_column  = out_result.error_column;

    // An empty input register never pushes back
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    // Only a last transaction may be held back
    a_only_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> !o_in_stall)
        else $error("non-last transaction stalled");

    // A new result appears only after a last transaction was consumed
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) && !(consume && r_in_last) |=> !o_out_valid)
        else $error("result appeared without a last transaction");

    // Error position is reported only with a UTF-8 error
    a_pos_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != utfv_pkg::STATUS_BAD_UTF8) |->
            (o_error_line == 32'd0 && o_error_column == 32'd0))
        else $error("error position without UTF-8 error");

endmodule
